@@ rtl/core/spq_pkg.sv @@
// shared types, codes and defaults for the stable priority queue
package spq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int DATA_BITS_DEF = 32;
    localparam int MAX_PRIO_DEF  = 16;

    localparam int PRIO_W     = 5;
    localparam int FIELD_DW   = 32;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 5;
    localparam int DATA_W_MAX = 64;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ENQ   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DEQ   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic                cmd;
        logic [PRIO_W-1:0]   prio_in;
        logic [FIELD_DW-1:0] data_in;
    } spq_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIELD_DW-1:0] data_out;
        logic [PRIO_W-1:0]   prio_out;
        logic [OCC_W-1:0]    occupancy;
    } spq_rsp_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [PRIO_W-1:0] prio;
    } spq_ctl_t;

endpackage

@@ rtl/core/spq_cell.sv @@
// one slot of the sorted chain: holds an entry and shifts with its neighbors
module spq_cell #(
    parameter int DATA_BITS = spq_pkg::DATA_BITS_DEF
) (
    input  logic                         clk,
    input  spq_pkg::spq_ctl_t            ctl,
    input  logic [DATA_BITS-1:0]         new_data,
    input  logic                         occ,
    input  logic                         left_keep,
    input  logic [spq_pkg::PRIO_W-1:0]   left_prio,
    input  logic [DATA_BITS-1:0]         left_data,
    input  logic [spq_pkg::PRIO_W-1:0]   right_prio,
    input  logic [DATA_BITS-1:0]         right_data,
    output logic                         keep,
    output logic [spq_pkg::PRIO_W-1:0]   prio,
    output logic [DATA_BITS-1:0]         data
);
    import spq_pkg::*;

    logic [PRIO_W-1:0]    prio_reg;
    logic [PRIO_W-1:0]    prio_next;
    logic [DATA_BITS-1:0] data_reg;
    logic [DATA_BITS-1:0] data_next;

    // entries at or below the new priority stay put
    assign keep = occ && (prio_reg <= ctl.prio);

    always_comb
    begin
        prio_next = prio_reg;
        data_next = data_reg;
        if (ctl.ins && !keep)
        begin
            if (left_keep)
            begin
                prio_next = ctl.prio;
                data_next = new_data;
            end
            else
            begin
                prio_next = left_prio;
                data_next = left_data;
            end
        end
        else if (ctl.rem)
        begin
            prio_next = right_prio;
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        data_reg <= data_next;
    end

    assign prio = prio_reg;
    assign data = data_reg;

endmodule

@@ rtl/core/stable_priority_queue.sv @@
// top level: stable bounded priority queue built as a shifting chain of cells
// a request's response is registered and valid in the cycle after acceptance
// one request per cycle while the response side keeps up; every cell compares and shifts in parallel
// a new request is taken while the response waits, if the response is taken the same cycle
// reset clears the entry count and the response valid; cell contents are not reset
module stable_priority_queue #(
    parameter int DEPTH     = spq_pkg::DEPTH_DEF,
    parameter int DATA_BITS = spq_pkg::DATA_BITS_DEF,
    parameter int MAX_PRIO  = spq_pkg::MAX_PRIO_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  spq_pkg::spq_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output spq_pkg::spq_rsp_t rsp
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    spq_rsp_t             rsp_reg;
    spq_rsp_t             rsp_next;

    logic                 fire;
    logic                 is_full;
    logic                 is_empty;
    logic [PRIO_W-1:0]    prio_sat;
    logic [DATA_W_MAX-1:0] data_wide;
    logic [DATA_W_MAX-1:0] front_wide;
    logic [DATA_BITS-1:0] new_data;
    spq_ctl_t             ctl;

    logic [DEPTH-1:0]     occ;
    logic [DEPTH-1:0]     keep_w;
    logic [PRIO_W-1:0]    prio_w [DEPTH];
    logic [DATA_BITS-1:0] data_w [DEPTH];

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign fire      = req_valid && req_ready;
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);

    assign prio_sat   = (int'(req.prio_in) > MAX_PRIO) ? PRIO_W'(MAX_PRIO) : req.prio_in;
    assign data_wide  = DATA_W_MAX'(req.data_in);
    assign new_data   = data_wide[DATA_BITS-1:0];
    assign front_wide = DATA_W_MAX'(data_w[0]);

    assign ctl.ins  = fire && (req.cmd == CMD_ENQ) && !is_full;
    assign ctl.rem  = fire && (req.cmd == CMD_DEQ) && !is_empty;
    assign ctl.prio = prio_sat;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign occ[i] = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            spq_cell #(.DATA_BITS(DATA_BITS)) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .new_data   (new_data),
                .occ        (occ[i]),
                .left_keep  (1'b1),
                .left_prio  (prio_sat),
                .left_data  (new_data),
                .right_prio (prio_w[i+1]),
                .right_data (data_w[i+1]),
                .keep       (keep_w[i]),
                .prio       (prio_w[i]),
                .data       (data_w[i])
            );
        end
        else if (i == DEPTH - 1)
        begin : g_tail
            spq_cell #(.DATA_BITS(DATA_BITS)) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .new_data   (new_data),
                .occ        (occ[i]),
                .left_keep  (keep_w[i-1]),
                .left_prio  (prio_w[i-1]),
                .left_data  (data_w[i-1]),
                .right_prio (prio_w[i]),
                .right_data (data_w[i]),
                .keep       (keep_w[i]),
                .prio       (prio_w[i]),
                .data       (data_w[i])
            );
        end
        else
        begin : g_mid
            spq_cell #(.DATA_BITS(DATA_BITS)) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .new_data   (new_data),
                .occ        (occ[i]),
                .left_keep  (keep_w[i-1]),
                .left_prio  (prio_w[i-1]),
                .left_data  (data_w[i-1]),
                .right_prio (prio_w[i+1]),
                .right_data (data_w[i+1]),
                .keep       (keep_w[i]),
                .prio       (prio_w[i]),
                .data       (data_w[i])
            );
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.rem)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        rsp_next           = rsp_reg;
        rsp_valid_next     = rsp_valid_reg;
        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (fire)
        begin
            rsp_valid_next     = 1'b1;
            rsp_next.data_out  = '0;
            rsp_next.prio_out  = '0;
            rsp_next.occupancy = OCC_W'(count_next);
            if (req.cmd == CMD_ENQ)
            begin
                rsp_next.status = is_full ? ST_FULL : ST_ENQ;
            end
            else if (is_empty)
            begin
                rsp_next.status = ST_EMPTY;
            end
            else
            begin
                rsp_next.status   = ST_DEQ;
                rsp_next.data_out = front_wide[FIELD_DW-1:0];
                rsp_next.prio_out = prio_w[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/core/spq_checker.sv @@
// port-level checks for the stable priority queue, bound to the top level
module spq_checker #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input spq_pkg::spq_rsp_t rsp
);
    import spq_pkg::*;

    // held response does not change
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // every accepted request yields a response next cycle
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("accepted request without response");

    // an empty output side always takes a request
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("not ready with no pending response");

    a_empty_resp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_EMPTY |->
            rsp.occupancy == '0 && rsp.data_out == '0 && rsp.prio_out == '0)
        else $error("bad empty response");

    a_full_resp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_FULL |->
            rsp.occupancy == OCC_W'(DEPTH) && rsp.data_out == '0)
        else $error("bad full response");

endmodule

bind stable_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);

@@ verif/stable_priority_queue_test.sv @@
// self-checking testbench for the stable bounded priority queue
module stable_priority_queue_test;
    import spq_pkg::*;

    localparam int STALL_LIMIT = 2000;

    class spq_shadow;
        logic [FIELD_DW-1:0] slot_data [DEPTH_DEF];
        logic [PRIO_W-1:0]   slot_prio [DEPTH_DEF];
        int                  fill;
        spq_rsp_t            due_rsp [$];
        int                  errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function void apply_request(spq_req_t r);
            spq_rsp_t          e;
            logic [PRIO_W-1:0] p;
            int                pos;
            int                i;
            e = '0;
            if (r.cmd == CMD_ENQ) begin
                p = (r.prio_in > MAX_PRIO_DEF) ? PRIO_W'(MAX_PRIO_DEF) : r.prio_in;
                if (fill >= DEPTH_DEF) begin
                    e.status = ST_FULL;
                end
                else begin
                    pos = 0;
                    while (pos < fill && slot_prio[pos] <= p)
                        pos++;
                    for (i = fill; i > pos; i--)
                    begin
                        slot_data[i] = slot_data[i-1];
                        slot_prio[i] = slot_prio[i-1];
                    end
                    slot_data[pos] = r.data_in;
                    slot_prio[pos] = p;
                    fill++;
                    e.status = ST_ENQ;
                end
            end
            else if (fill == 0) begin
                e.status = ST_EMPTY;
            end
            else begin
                e.data_out = slot_data[0];
                e.prio_out = slot_prio[0];
                for (i = 1; i < fill; i++)
                begin
                    slot_data[i-1] = slot_data[i];
                    slot_prio[i-1] = slot_prio[i];
                end
                fill--;
                e.status = ST_DEQ;
            end
            e.occupancy = OCC_W'(fill);
            due_rsp.push_back(e);
        endfunction

        function void compare_response(spq_rsp_t a);
            spq_rsp_t e;
            if (due_rsp.size() == 0) begin
                $display("%0t: unexpected response %h", $time, a);
                errors++;
                return;
            end
            e = due_rsp.pop_front();
            if (a.status !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
                errors++;
            end
            if (a.data_out !== e.data_out) begin
                $display("%0t: data_out expected %h actual %h", $time, e.data_out, a.data_out);
                errors++;
            end
            if (a.prio_out !== e.prio_out) begin
                $display("%0t: prio_out expected %0d actual %0d", $time, e.prio_out, a.prio_out);
                errors++;
            end
            if (a.occupancy !== e.occupancy) begin
                $display("%0t: occupancy expected %0d actual %0d", $time, e.occupancy,
                         a.occupancy);
                errors++;
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    spq_req_t req;
    logic     rsp_valid;
    logic     rsp_ready;
    spq_rsp_t rsp;

    spq_shadow shadow = new();
    int        send_idle_pct;
    int        recv_idle_pct;
    int        stall_cycles;

    stable_priority_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // response side: check, then pick the next ready
    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
            shadow.compare_response(rsp);
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_request(input spq_req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        shadow.apply_request(r);
    endtask

    task automatic make_request(input logic c, input logic [PRIO_W-1:0] p,
                                input logic [FIELD_DW-1:0] d);
        spq_req_t r;
        r.cmd     = c;
        r.prio_in = p;
        r.data_in = d;
        push_request(r);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (shadow.due_rsp.size() != 0);
    endtask

    task automatic run_directed();
        logic [PRIO_W-1:0]   fill_prio [16];
        logic [FIELD_DW-1:0] fill_data [16];
        int                  k;
        fill_prio = '{5'd31, 5'd17, 5'd16, 5'd0, 5'd5, 5'd5, 5'd5, 5'd0,
                      5'd1, 5'd2, 5'd3, 5'd4, 5'd15, 5'd14, 5'd5, 5'd0};
        fill_data = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h0000_0002,
                      32'h0000_0003, 32'h0000_0004, 32'h0000_0005, 32'h8000_0000,
                      32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h7FFF_FFFF, 32'hFFFF_FFFE,
                      32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h1234_5678, 32'hDEAD_BEEF};
        // dequeue on empty
        make_request(CMD_DEQ, 5'd0, 32'hFFFF_FFFF);
        for (k = 0; k < 16; k++)
            make_request(CMD_ENQ, fill_prio[k], fill_data[k]);
        // enqueue on full
        make_request(CMD_ENQ, 5'd0, 32'hCAFE_F00D);
        for (k = 0; k < 3; k++)
            make_request(CMD_DEQ, 5'd31, 32'h0);
    endtask

    task automatic run_random(input int snd_pct, input int rcv_pct, input int count);
        int                enq_pct;
        int                n;
        logic              c;
        logic [PRIO_W-1:0] p;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        enq_pct       = 50;
        for (n = 0; n < count; n++)
        begin
            // swing the fill level between empty and full
            if (n % 40 == 0) begin
                case ($urandom_range(2))
                    0:       enq_pct = 25;
                    1:       enq_pct = 50;
                    default: enq_pct = 80;
                endcase
            end
            c = ($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
            if ($urandom_range(1) == 0)
                p = PRIO_W'($urandom_range(3));
            else
                p = PRIO_W'($urandom_range(31));
            make_request(c, p, $urandom);
        end
        wait_drained();
    endtask

    initial
    begin
        stall_cycles  = 0;
        send_idle_pct = 13;
        recv_idle_pct = 74;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        rsp_ready <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        wait_drained();
        run_random(13, 74, 285);
        run_random(74, 13, 285);
        run_random(0, 0, 285);
        repeat (4) @(posedge clk);
        if (shadow.errors == 0 && shadow.due_rsp.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
